[rtl/dhf_pkg.sv]
package dhf_pkg;

    // frame and window limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_RADIUS = 3;
    localparam int HEIGHT_CAP = 4096;

    // field widths
    localparam int DEPTH_W = 16;
    localparam int COL_W   = 10;
    localparam int ROW_W   = 12;
    localparam int FW_W    = 11;
    localparam int FH_W    = 13;
    localparam int RAD_W   = 2;
    localparam int CFG_W   = 13;
    localparam int CFG_IW  = 2;

    // line store: sixteen row slots of one full row each, enough for the
    // window rows plus the input row running ahead on narrow frames
    localparam int SLOT_W  = 4;
    localparam int MEM_AW  = SLOT_W + COL_W;
    localparam int MEM_D   = 1 << MEM_AW;

    // position, accumulation and offset widths
    localparam int POS_W   = 23;
    localparam int SUM_W   = 22;
    localparam int CNT_W   = 6;
    localparam int OFS_W   = 4;
    localparam int WIN_MAX = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);

    // configuration register indexes
    typedef enum logic [CFG_IW-1:0] {
        CFG_FRAME_WIDTH   = 2'd0,
        CFG_FRAME_HEIGHT  = 2'd1,
        CFG_KERNEL_RADIUS = 2'd2
    } t_cfg_idx;

    // divider handshake
    typedef struct packed {
        logic                start;
        logic [SUM_W-1:0]    dividend;
        logic [CNT_W-1:0]    divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [DEPTH_W-1:0]  quot;
    } t_div_rsp;

endpackage

[rtl/dhf_in_if.sv]
interface dhf_in_if
    import dhf_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               func;
    logic [DEPTH_W-1:0] depth;

    modport source (output valid, output func, output depth, input ready);
    modport sink   (input valid, input func, input depth, output ready);
endinterface

[rtl/dhf_out_if.sv]
interface dhf_out_if
    import dhf_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [DEPTH_W-1:0] depth_out;
    logic [COL_W-1:0]   out_col;
    logic [ROW_W-1:0]   out_row;
    logic               was_filled;
    logic               last_of_frame;

    modport source (output valid, output depth_out, output out_col, output out_row,
                    output was_filled, output last_of_frame, input ready);
    modport sink   (input valid, input depth_out, input out_col, input out_row,
                    input was_filled, input last_of_frame, output ready);
endinterface

[rtl/depth_hole_fill_mean_unit.sv]
// channel   dir   payload                                              handshake
// s_in      in    func, depth                                          valid/ready
// m_out     out   depth_out, out_col, out_row, was_filled, last_of_frame valid/ready
// i_cfg_*   in    wr_en, idx, data (frame_width, frame_height, radius) write only
//
// an item whose centre pixel is nonzero is passed on as it is; a hole is
// filled by a walk over its (2r+1)^2 window and a division, paced by
// the single read port of the line store and the serial divider
// one item is worked on at a time; the result waits in an output register
// reset is synchronous, active low; a config write to an existing register restarts the frame
module depth_hole_fill_mean_unit
    import dhf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    dhf_in_if.sink            s_in,
    dhf_out_if.source         m_out,
    input  logic              i_cfg_wr_en,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CTR   = 8'b0000_0010,
        S_CTRW  = 8'b0000_0100,
        S_SCAN  = 8'b0000_1000,
        S_SDRN  = 8'b0001_0000,
        S_DIV   = 8'b0010_0000,
        S_DWAIT = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic [FW_W-1:0]  r_fw;
    logic [FH_W-1:0]  r_fh;
    logic [RAD_W-1:0] r_rad;

    logic [COL_W-1:0]  r_in_col, n_in_col;
    logic [SLOT_W-1:0] r_in_slot, n_in_slot;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [COL_W-1:0]  r_ocol, n_ocol;
    logic [ROW_W-1:0]  r_orow, n_orow;

    logic signed [OFS_W-1:0] r_dr, n_dr, r_dc, n_dc;
    logic                    r_pend, n_pend;
    logic [SUM_W-1:0]        r_sum, n_sum;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [DEPTH_W-1:0]      r_res, n_res;
    logic                    r_fil, n_fil;

    logic               r_out_valid;
    logic [DEPTH_W-1:0] r_out_depth;
    logic [COL_W-1:0]   r_out_col;
    logic [ROW_W-1:0]   r_out_row;
    logic               r_out_filled;
    logic               r_out_last;

    logic [FW_W-1:0]    w_eff;
    logic [FH_W-1:0]    h_eff;
    logic [POS_W-1:0]   frame_px;
    logic [POS_W-1:0]   lag;
    logic               in_fire, out_fire, emit_ok, is_last, clr;
    logic               cfg_hit;
    logic               mem_we;
    logic [MEM_AW-1:0]  mem_waddr, mem_raddr;
    logic [DEPTH_W-1:0] mem_wdata, mem_rdata;
    logic signed [FH_W:0]   rr;
    logic signed [COL_W+1:0] cc;
    logic                   in_frame;
    logic signed [OFS_W-1:0] rad_s, neg_rad;
    t_div_req               div_req;
    t_div_rsp               div_rsp;

    // effective frame geometry
    always_comb begin
        w_eff = r_fw;
        if (r_fw == '0) w_eff = FW_W'(1);
        else if (r_fw > FW_W'(MAX_WIDTH)) w_eff = FW_W'(MAX_WIDTH);
        h_eff = r_fh;
        if (r_fh == '0) h_eff = FH_W'(1);
        else if (r_fh > FH_W'(HEIGHT_CAP)) h_eff = FH_W'(HEIGHT_CAP);
        frame_px = POS_W'(w_eff) * POS_W'(h_eff);
        lag      = POS_W'(r_rad) * POS_W'(w_eff) + POS_W'(r_rad);
        rad_s    = signed'({{(OFS_W-RAD_W){1'b0}}, r_rad});
        neg_rad  = -rad_s;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw  <= FW_W'(640);
            r_fh  <= FH_W'(480);
            r_rad <= RAD_W'(1);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_FRAME_WIDTH:   r_fw  <= i_cfg_data[FW_W-1:0];
                CFG_FRAME_HEIGHT:  r_fh  <= i_cfg_data[FH_W-1:0];
                CFG_KERNEL_RADIUS: r_rad <= i_cfg_data[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // only a write to an existing register restarts the frame
    assign cfg_hit = i_cfg_wr_en && (i_cfg_idx == CFG_FRAME_WIDTH
                  || i_cfg_idx == CFG_FRAME_HEIGHT || i_cfg_idx == CFG_KERNEL_RADIUS);

    assign s_in.ready = (r_state == S_IDLE);
    assign in_fire    = s_in.valid && s_in.ready;
    assign out_fire   = r_out_valid && m_out.ready;
    assign emit_ok    = !r_out_valid || m_out.ready;
    assign is_last    = (r_orow == ROW_W'(h_eff - 1'b1)) && (r_ocol == COL_W'(w_eff - 1'b1));

    // store the incoming sample at its row slot and column
    assign mem_we    = in_fire;
    assign mem_waddr = {r_in_slot, r_in_col};
    assign mem_wdata = (r_pos < frame_px && !s_in.func) ? s_in.depth : '0;

    // neighbour position and frame bounds
    always_comb begin
        rr       = signed'({2'b00, r_orow}) + (FH_W+1)'(r_dr);
        cc       = signed'({2'b00, r_ocol}) + (COL_W+2)'(r_dc);
        in_frame = (rr >= 0) && (rr < signed'({1'b0, h_eff}))
                && (cc >= 0) && (cc < signed'({1'b0, w_eff}));
    end

    // read address: centre or current neighbour
    always_comb begin
        if (r_state == S_SCAN) mem_raddr = {rr[SLOT_W-1:0], cc[COL_W-1:0]};
        else                   mem_raddr = {r_orow[SLOT_W-1:0], r_ocol};
    end

    dhf_line_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign div_req.start    = (r_state == S_DIV) && (r_cnt != '0);
    assign div_req.dividend = r_sum;
    assign div_req.divisor  = r_cnt;

    dhf_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_in_col  = r_in_col;
        n_in_slot = r_in_slot;
        n_pos     = r_pos;
        n_ocol    = r_ocol;
        n_orow    = r_orow;
        n_dr      = r_dr;
        n_dc      = r_dc;
        n_pend    = 1'b0;
        n_sum     = r_sum;
        n_cnt     = r_cnt;
        n_res     = r_res;
        n_fil     = r_fil;
        clr       = 1'b0;

        // gather the neighbour read issued last cycle
        if (r_pend && mem_rdata != '0) begin
            n_sum = r_sum + SUM_W'(mem_rdata);
            n_cnt = r_cnt + 1'b1;
        end

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_pos = r_pos + 1'b1;
                    if ({1'b0, r_in_col} == FW_W'(w_eff - 1'b1)) begin
                        n_in_col  = '0;
                        n_in_slot = r_in_slot + 1'b1;
                    end else begin
                        n_in_col = r_in_col + 1'b1;
                    end
                    if (r_pos >= lag) n_state = S_CTR;
                end
            end
            S_CTR: n_state = S_CTRW;
            S_CTRW: begin
                n_sum = '0;
                n_cnt = '0;
                n_dr  = neg_rad;
                n_dc  = neg_rad;
                if (mem_rdata != '0) begin
                    n_res   = mem_rdata;
                    n_fil   = 1'b0;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                n_pend = in_frame;
                if (r_dc == rad_s) begin
                    n_dc = neg_rad;
                    n_dr = r_dr + 1'b1;
                    if (r_dr == rad_s) n_state = S_SDRN;
                end else begin
                    n_dc = r_dc + 1'b1;
                end
            end
            S_SDRN: n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == '0) begin
                    n_res   = '0;
                    n_fil   = 1'b0;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_DWAIT;
                end
            end
            S_DWAIT: begin
                if (div_rsp.done) begin
                    n_res   = div_rsp.quot;
                    n_fil   = 1'b1;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (emit_ok) begin
                    n_state = S_IDLE;
                    if (is_last) begin
                        clr = 1'b1;
                    end else if ({1'b0, r_ocol} == FW_W'(w_eff - 1'b1)) begin
                        n_ocol = '0;
                        n_orow = r_orow + 1'b1;
                    end else begin
                        n_ocol = r_ocol + 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        // frame restart
        if (clr || cfg_hit) begin
            n_in_col  = '0;
            n_in_slot = '0;
            n_pos     = '0;
            n_ocol    = '0;
            n_orow    = '0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_in_col  <= '0;
            r_in_slot <= '0;
            r_pos     <= '0;
            r_ocol    <= '0;
            r_orow    <= '0;
            r_pend    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_in_col  <= n_in_col;
            r_in_slot <= n_in_slot;
            r_pos     <= n_pos;
            r_ocol    <= n_ocol;
            r_orow    <= n_orow;
            r_pend    <= n_pend;
        end
    end

    // window walk and accumulator
    always_ff @(posedge i_clk) begin
        r_dr  <= n_dr;
        r_dc  <= n_dc;
        r_sum <= n_sum;
        r_cnt <= n_cnt;
        r_res <= n_res;
        r_fil <= n_fil;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_EMIT && emit_ok) begin
            r_out_valid <= 1'b1;
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && emit_ok) begin
            r_out_depth  <= r_res;
            r_out_col    <= r_ocol;
            r_out_row    <= r_orow;
            r_out_filled <= r_fil;
            r_out_last   <= is_last;
        end
    end

    assign m_out.valid         = r_out_valid;
    assign m_out.depth_out     = r_out_depth;
    assign m_out.out_col       = r_out_col;
    assign m_out.out_row       = r_out_row;
    assign m_out.was_filled    = r_out_filled;
    assign m_out.last_of_frame = r_out_last;

    // a filled pixel is a mean of nonzero samples
    a_fill_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_filled |-> r_out_depth != '0)
        else $error("filled pixel is zero");

    // at most one window of nonzero samples is counted
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_cnt <= CNT_W'(WIN_MAX))
        else $error("neighbour count out of range");

    // divider answers only while the sequencer waits for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> r_state == S_DWAIT)
        else $error("divider result without a waiting request");

    // the result register is never overwritten before it is taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_out.ready |=> r_out_valid)
        else $error("pending result dropped");

    // output column stays inside the row
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT |-> {1'b0, r_ocol} < w_eff)
        else $error("output column beyond frame width");

endmodule

[rtl/dhf_line_mem.sv]
module dhf_line_mem
    import dhf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [MEM_AW-1:0]  i_waddr,
    input  logic [DEPTH_W-1:0] i_wdata,
    input  logic [MEM_AW-1:0]  i_raddr,
    output logic [DEPTH_W-1:0] o_rdata
);

    logic [DEPTH_W-1:0] r_mem [MEM_D];
    logic [DEPTH_W-1:0] r_rdata;

    // single write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/dhf_divider.sv]
module dhf_divider
    import dhf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W:0]    r_rem;
    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_div;

    logic [CNT_W:0]    shifted;
    logic [CNT_W+1:0]  trial;

    // one quotient bit per cycle, restoring
    always_comb begin
        shifted = {r_rem[CNT_W-1:0], r_quo[SUM_W-1]};
        trial   = {1'b0, shifted} - {2'b00, r_div};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(SUM_W - 1);
            end else if (r_busy) begin
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= trial[CNT_W+1] ? shifted : trial[CNT_W:0];
            r_quo <= {r_quo[SUM_W-2:0], ~trial[CNT_W+1]};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo[DEPTH_W-1:0];

endmodule

[sim/depth_hole_fill_mean_unit_tb.sv]
`timescale 1ns / 1ps

module depth_hole_fill_mean_unit_tb;
    import dhf_pkg::*;

    // one output pixel as the block reports it
    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic               filled;
        logic               last;
    } t_px_res;

    // directed stimulus row: either a register write or a pixel request
    typedef struct {
        bit                 is_cfg;
        logic [CFG_IW-1:0]  idx;
        logic [CFG_W-1:0]   data;
        bit                 func;
        logic [DEPTH_W-1:0] depth;
        bit                 typed;
        t_px_res            res;
    } t_dir_row;

    localparam logic [CFG_IW-1:0] CFG_UNUSED = 2'd3;
    localparam bit FN_PIXEL = 1'b0;
    localparam bit FN_DRAIN = 1'b1;
    localparam int STORE_LEN = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
    localparam int SETTLE_CYCLES = 150;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int RAND_ITEMS = 650;
    localparam int WIDE_ITEMS = 120;
    localparam int TALL_ITEMS = 60;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_wr_en = 1'b0;
    logic [CFG_IW-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    dhf_in_if in_if();
    dhf_out_if out_if();

    depth_hole_fill_mean_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_in        (in_if),
        .m_out       (out_if),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // shadow of the filter state
    logic [DEPTH_W-1:0] px_hist [STORE_LEN];
    logic [FW_W-1:0]  sh_width;
    logic [FH_W-1:0]  sh_height;
    logic [RAD_W-1:0] sh_radius;
    int in_c, in_r, out_c, out_r;

    t_px_res pending_px[$];
    int n_bad = 0;
    int cycles = 0;
    bit quiet = 1'b0;
    int hold_req = 0;

    function automatic int eff_width();
        return (sh_width < 1) ? 1 : (sh_width > MAX_WIDTH) ? MAX_WIDTH : int'(sh_width);
    endfunction

    function automatic int eff_height();
        return (sh_height < 1) ? 1 : (sh_height > HEIGHT_CAP) ? HEIGHT_CAP : int'(sh_height);
    endfunction

    function automatic int eff_radius();
        return (sh_radius > MAX_RADIUS) ? MAX_RADIUS : int'(sh_radius);
    endfunction

    function automatic void restart_frame();
        in_c = 0;
        in_r = 0;
        out_c = 0;
        out_r = 0;
    endfunction

    function automatic void shadow_reset();
        foreach (px_hist[k]) px_hist[k] = '0;
        sh_width = 11'd640;
        sh_height = 13'd480;
        sh_radius = 2'd1;
        restart_frame();
    endfunction

    function automatic void shadow_cfg(logic [CFG_IW-1:0] idx, logic [CFG_W-1:0] data);
        case (idx)
            CFG_FRAME_WIDTH:   sh_width = data[FW_W-1:0];
            CFG_FRAME_HEIGHT:  sh_height = data[FH_W-1:0];
            CFG_KERNEL_RADIUS: sh_radius = data[RAD_W-1:0];
            default: return;
        endcase
        restart_frame();
    endfunction

    // hole fill of one accepted request; returns 1 when a pixel comes out
    function automatic bit fill_pixel(bit func, logic [DEPTH_W-1:0] depth, output t_px_res res);
        int w, h, r, lag, pos, centre, sum, cnt, rr, cc, v;
        w = eff_width();
        h = eff_height();
        r = eff_radius();
        lag = r * w + r;
        pos = in_r * w + in_c;
        res = '0;
        px_hist[pos % STORE_LEN] = (pos < w * h && func == FN_PIXEL) ? depth : '0;
        in_c++;
        if (in_c >= w) begin
            in_c = 0;
            in_r++;
        end
        if (pos < lag) return 1'b0;
        centre = px_hist[(pos - lag) % STORE_LEN];
        if (centre != 0) begin
            res.depth = DEPTH_W'(centre);
        end else begin
            sum = 0;
            cnt = 0;
            for (rr = out_r - r; rr <= out_r + r; rr++) begin
                for (cc = out_c - r; cc <= out_c + r; cc++) begin
                    if (rr >= 0 && rr < h && cc >= 0 && cc < w) begin
                        v = px_hist[(rr * w + cc) % STORE_LEN];
                        if (v != 0) begin
                            sum += v;
                            cnt++;
                        end
                    end
                end
            end
            if (cnt != 0) begin
                res.depth = DEPTH_W'(sum / cnt);
                res.filled = 1'b1;
            end
        end
        res.col = COL_W'(out_c);
        res.row = ROW_W'(out_r);
        res.last = (out_r == h - 1 && out_c == w - 1);
        if (res.last) begin
            restart_frame();
        end else begin
            out_c++;
            if (out_c >= w) begin
                out_c = 0;
                out_r++;
            end
        end
        return 1'b1;
    endfunction

    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, 8);
    endfunction

    // pixel request: idle gap, then hold valid until accepted
    task automatic send_px(bit func, logic [DEPTH_W-1:0] depth, bit typed = 0,
                           t_px_res typed_res = '0);
        int gap;
        t_px_res res;
        gap = draw_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.func <= func;
        in_if.depth <= depth;
        do @(posedge i_clk); while (!in_if.ready);
        if (fill_pixel(func, depth, res)) pending_px.push_back(typed ? typed_res : res);
    endtask

    // stop offering, let every result come back and the block settle
    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (pending_px.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write enable stays high; the caller drops it after the last write
    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        shadow_cfg(idx, data);
    endtask

    task automatic set_frame(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h, logic [CFG_W-1:0] r);
        wait_idle();
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
        write_reg(CFG_KERNEL_RADIUS, r);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [DEPTH_W-1:0] rand_depth(int hole_pct);
        if ($urandom_range(0, 99) < hole_pct) return '0;
        case ($urandom_range(0, 5))
            0: return 16'hFFFF;
            1: return DEPTH_W'($urandom_range(1, 15));
            default: return DEPTH_W'($urandom_range(1, 65535));
        endcase
    endfunction

    // output side: random stall per result, plus a long hold on request
    int stall_left = 0;
    int hold_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (pending_px.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("unexpected pixel col %0d row %0d depth %0h",
                                 out_if.out_col, out_if.out_row, out_if.depth_out);
                end else begin
                    t_px_res exp_px;
                    exp_px = pending_px.pop_front();
                    if (out_if.depth_out !== exp_px.depth || out_if.out_col !== exp_px.col ||
                        out_if.out_row !== exp_px.row || out_if.was_filled !== exp_px.filled ||
                        out_if.last_of_frame !== exp_px.last) begin
                        n_bad++;
                        if (n_bad <= 10)
                            $display("pixel mismatch exp d=%0h c=%0d r=%0d f=%0b l=%0b got d=%0h c=%0d r=%0d f=%0b l=%0b",
                                     exp_px.depth, exp_px.col, exp_px.row, exp_px.filled,
                                     exp_px.last, out_if.depth_out, out_if.out_col,
                                     out_if.out_row, out_if.was_filled, out_if.last_of_frame);
                    end
                end
                stall_left = draw_gap();
            end else if (stall_left > 0) begin
                stall_left--;
            end
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end else if (hold_left > 0) begin
                hold_left--;
            end
            out_if.ready <= (stall_left == 0) && (hold_left == 0);
        end
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL depth_hole_fill_mean_unit");
            $finish;
        end
    end

    t_dir_row dir_tab[] = '{
        // 4x2 frame, radius 0: each pixel comes straight back
        '{1, CFG_FRAME_WIDTH,   13'd4, 0, 0, 0, '0},
        '{1, CFG_FRAME_HEIGHT,  13'd2, 0, 0, 0, '0},
        '{1, CFG_KERNEL_RADIUS, 13'd0, 0, 0, 0, '0},
        '{1, CFG_UNUSED,        13'h1FFF, 0, 0, 0, '0},
        '{0, CFG_UNUSED, 0, FN_PIXEL, 16'hFFFF, 1, '{16'hFFFF, 10'd0, 12'd0, 1'b0, 1'b0}},
        '{0, CFG_UNUSED, 0, FN_PIXEL, 16'h0000, 1, '{16'h0000, 10'd1, 12'd0, 1'b0, 1'b0}},
        '{0, CFG_UNUSED, 0, FN_PIXEL, 16'h0001, 1, '{16'h0001, 10'd2, 12'd0, 1'b0, 1'b0}},
        '{0, CFG_UNUSED, 0, FN_DRAIN, 16'h1234, 1, '{16'h0000, 10'd3, 12'd0, 1'b0, 1'b0}},
        '{0, CFG_UNUSED, 0, FN_PIXEL, 16'h8000, 1, '{16'h8000, 10'd0, 12'd1, 1'b0, 1'b0}},
        '{0, CFG_UNUSED, 0, FN_PIXEL, 16'h7FFF, 1, '{16'h7FFF, 10'd1, 12'd1, 1'b0, 1'b0}},
        '{0, CFG_UNUSED, 0, FN_DRAIN, 16'hFFFF, 1, '{16'h0000, 10'd2, 12'd1, 1'b0, 1'b0}},
        '{0, CFG_UNUSED, 0, FN_PIXEL, 16'h00FF, 1, '{16'h00FF, 10'd3, 12'd1, 1'b0, 1'b1}},
        // 3x3 frame, radius 1: holes at corners, edges, and the centre
        '{1, CFG_FRAME_WIDTH,   13'd3, 0, 0, 0, '0},
        '{1, CFG_FRAME_HEIGHT,  13'd3, 0, 0, 0, '0},
        '{1, CFG_KERNEL_RADIUS, 13'd1, 0, 0, 0, '0},
        '{0, CFG_UNUSED, 0, FN_PIXEL, 16'h0000, 0, '0},
        '{0, CFG_UNUSED, 0, FN_PIXEL, 16'hFFFF, 0, '0},
        '{0, CFG_UNUSED, 0, FN_PIXEL, 16'h0000, 0, '0},
        '{0, CFG_UNUSED, 0, FN_PIXEL, 16'hFFFE, 0, '0},
        '{0, CFG_UNUSED, 0, FN_DRAIN, 16'h5555, 0, '0},
        '{0, CFG_UNUSED, 0, FN_PIXEL, 16'h0003, 0, '0},
        '{0, CFG_UNUSED, 0, FN_PIXEL, 16'h0000, 0, '0},
        '{0, CFG_UNUSED, 0, FN_PIXEL, 16'h0000, 0, '0},
        '{0, CFG_UNUSED, 0, FN_PIXEL, 16'h0000, 0, '0},
        // tail: real pixels past the frame end count as drain steps
        '{0, CFG_UNUSED, 0, FN_PIXEL, 16'hABCD, 0, '0},
        '{0, CFG_UNUSED, 0, FN_PIXEL, 16'hFFFF, 0, '0},
        '{0, CFG_UNUSED, 0, FN_DRAIN, 16'h0000, 0, '0},
        '{0, CFG_UNUSED, 0, FN_DRAIN, 16'hAAAA, 0, '0}
    };

    initial begin
        int n_rand, w, h, r, items, hole_pct, phase;
        in_if.valid = 1'b0;
        in_if.func = FN_PIXEL;
        in_if.depth = '0;
        shadow_reset();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (dir_tab[k]) begin
            if (dir_tab[k].is_cfg) begin
                wait_idle();
                write_reg(dir_tab[k].idx, dir_tab[k].data);
                i_cfg_wr_en <= 1'b0;
            end else begin
                send_px(dir_tab[k].func, dir_tab[k].depth, dir_tab[k].typed, dir_tab[k].res);
            end
        end

        // widest row (width above range clamps), one row, radius 0, cut short
        set_frame(13'd2047, 13'd1, 13'd0);
        for (int k = 0; k < WIDE_ITEMS; k++) send_px(FN_PIXEL, rand_depth(20));

        // tall frame (height above range clamps), one column, widest radius, cut short
        set_frame(13'd1, 13'h1FFF, 13'd3);
        for (int k = 0; k < TALL_ITEMS; k++) send_px($urandom_range(0, 49) == 0, rand_depth(4));

        // random frames, mostly complete with their tail, some cut short, some run past the tail
        n_rand = 0;
        phase = 0;
        while (n_rand < RAND_ITEMS) begin
            w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
            h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
            r = $urandom_range(0, 8191);
            quiet = 1'b0;
            set_frame(CFG_W'(w), CFG_W'(h), CFG_W'(r));
            quiet = ($urandom_range(0, 3) == 0);
            w = eff_width();
            h = eff_height();
            items = w * h + eff_radius() * w + eff_radius();
            if ($urandom_range(0, 6) == 0) items = $urandom_range(1, items);
            else if ($urandom_range(0, 4) == 0) items += $urandom_range(1, items);
            hole_pct = $urandom_range(10, 70);
            if (phase == 2) begin
                quiet = 1'b1;
                hold_req = 300;
            end
            for (int k = 0; k < items; k++) begin
                if ($urandom_range(0, 19) == 0)
                    send_px(FN_DRAIN, DEPTH_W'($urandom_range(0, 65535)));
                else
                    send_px(FN_PIXEL, rand_depth(hole_pct));
            end
            n_rand += items;
            phase++;
        end

        quiet = 1'b0;
        wait_idle();
        if (n_bad == 0 && pending_px.size() == 0) begin
            $display("PASS depth_hole_fill_mean_unit");
        end else begin
            $display("FAIL depth_hole_fill_mean_unit");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/dhf_pkg.sv
rtl/dhf_in_if.sv
rtl/dhf_out_if.sv
rtl/dhf_line_mem.sv
rtl/dhf_divider.sv
rtl/depth_hole_fill_mean_unit.sv
sim/depth_hole_fill_mean_unit_tb.sv
